// ===== hdl/grq_pkg.sv =====
package grq_pkg;

  localparam int VERTEX_W     = 6;
  localparam int COUNT_W      = 7;
  localparam int COUNT_RESET  = 64;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]          command;
    logic [VERTEX_W-1:0] source_vertex;
    logic [VERTEX_W-1:0] target_vertex;
  } grq_req_t;

  typedef struct packed {
    logic path_exists;
    logic bad_vertex;
  } grq_rsp_t;

endpackage

// ===== hdl/graph_reachability_query_top.sv =====
// Add edge: source row read and update, then target row read and update. Clear sweeps every row.
// Query with a bad or equal vertex answers from idle. Walk query: per visited vertex a queue read,
// adjacency row read, row merge, a push per new vertex and an empty push check; a final queue check.
// Throughput: one request at a time; each visited vertex costs a queue read and a row read.
// Reset: synchronous active-low; afterwards busy stays high while the adjacency memory is swept
// to zero. Results are one-cycle strobes; the receiver cannot stall.
module graph_reachability_query_top #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              start,
  output logic                              busy,
  input  grq_pkg::grq_req_t                 in_data,
  // result channel
  output logic                              out_valid,
  output grq_pkg::grq_rsp_t                 out_data,
  // vertex count register
  input  logic                              cfg_we,
  input  logic [grq_pkg::COUNT_W-1:0]       cfg_wdata
);

  // Vertex index width and a compare width that holds both the register and MAX_VERTICES.
  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int CW = (NW > grq_pkg::COUNT_W) ? NW : grq_pkg::COUNT_W;

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_ADD_S  = 4'd2;
  localparam logic [3:0] ST_ADD_T  = 4'd3;
  localparam logic [3:0] ST_Q_POP  = 4'd4;
  localparam logic [3:0] ST_Q_ADDR = 4'd5;
  localparam logic [3:0] ST_Q_ROW  = 4'd6;
  localparam logic [3:0] ST_Q_PUSH = 4'd7;

  localparam logic [VW-1:0] LAST_ROW = VW'(MAX_VERTICES - 1);

  // Control and payload registers
  logic [3:0]                  state_r, state_nxt;
  logic [VW-1:0]               clr_idx_r, clr_idx_nxt;
  logic [VW-1:0]               src_r, src_nxt;
  logic [VW-1:0]               tgt_r, tgt_nxt;
  logic [VW:0]                 head_r, head_nxt;
  logic [VW:0]                 tail_r, tail_nxt;
  logic [MAX_VERTICES-1:0]     visited_r, visited_nxt;
  logic [MAX_VERTICES-1:0]     new_r, new_nxt;
  logic [grq_pkg::COUNT_W-1:0] vcount_r;
  logic                        out_valid_r, out_valid_nxt;
  grq_pkg::grq_rsp_t           out_data_r, out_data_nxt;

  // Adjacency row memory: one row per vertex, one read and one write port.
  logic [MAX_VERTICES-1:0]     adj_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0]     adj_rdata_r;
  logic                        adj_re, adj_we;
  logic [VW-1:0]               adj_raddr, adj_waddr;
  logic [MAX_VERTICES-1:0]     adj_wdata;

  // Pending vertex queue memory.
  logic [VW-1:0]               q_mem [MAX_VERTICES];
  logic [VW-1:0]               q_rdata_r;
  logic                        q_re, q_we;
  logic [VW-1:0]               q_raddr, q_waddr, q_wdata;

  // Decode helpers
  logic [CW-1:0]               n_act;
  logic [MAX_VERTICES-1:0]     act_mask;
  logic [VW-1:0]               in_src, in_tgt;
  logic                        in_bad;
  logic [MAX_VERTICES-1:0]     reach;
  logic [VW-1:0]               ffs_idx;

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_src = VW'(in_data.source_vertex);
  assign in_tgt = VW'(in_data.target_vertex);

  // Active count saturates at MAX_VERTICES.
  always_comb begin
    if (CW'(vcount_r) > CW'(MAX_VERTICES)) begin
      n_act = CW'(MAX_VERTICES);
    end else begin
      n_act = CW'(vcount_r);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      act_mask[i] = (CW'(i) < n_act);
    end
  end

  assign in_bad = (CW'(in_data.source_vertex) >= n_act) ||
                  (CW'(in_data.target_vertex) >= n_act);

  // Newly reached neighbors of the current vertex. The current vertex is already
  // visited, so its diagonal bit drops out here too.
  assign reach = adj_rdata_r & ~visited_r & act_mask;

  // Lowest set bit of the pending push set.
  always_comb begin
    ffs_idx = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (new_r[i]) begin
        ffs_idx = VW'(i);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    src_nxt       = src_r;
    tgt_nxt       = tgt_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    visited_nxt   = visited_r;
    new_nxt       = new_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    adj_re        = 1'b0;
    adj_raddr     = src_r;
    adj_we        = 1'b0;
    adj_waddr     = clr_idx_r;
    adj_wdata     = '0;
    q_re          = 1'b0;
    q_raddr       = head_r[VW-1:0];
    q_we          = 1'b0;
    q_waddr       = tail_r[VW-1:0];
    q_wdata       = ffs_idx;

    case (state_r)
      // Sweep every row to zero, one row a cycle.
      ST_CLEAR: begin
        adj_we    = 1'b1;
        adj_waddr = clr_idx_r;
        adj_wdata = '0;
        if (clr_idx_r == LAST_ROW) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + VW'(1);
        end
      end

      ST_IDLE: begin
        if (start) begin
          src_nxt = in_src;
          tgt_nxt = in_tgt;
          case (in_data.command)
            grq_pkg::CMD_ADD: begin
              // Drop an edge with an endpoint outside the active range.
              if (!in_bad) begin
                adj_re    = 1'b1;
                adj_raddr = in_src;
                state_nxt = ST_ADD_S;
              end
            end
            grq_pkg::CMD_CLEAR: begin
              clr_idx_nxt = '0;
              state_nxt   = ST_CLEAR;
            end
            grq_pkg::CMD_QUERY: begin
              if (in_bad) begin
                out_valid_nxt            = 1'b1;
                out_data_nxt.path_exists = 1'b0;
                out_data_nxt.bad_vertex  = 1'b1;
              end else if (in_src == in_tgt) begin
                out_valid_nxt            = 1'b1;
                out_data_nxt.path_exists = 1'b1;
                out_data_nxt.bad_vertex  = 1'b0;
              end else begin
                // Seed the walk: source visited and queued.
                visited_nxt = MAX_VERTICES'(1) << in_src;
                q_we        = 1'b1;
                q_waddr     = '0;
                q_wdata     = in_src;
                head_nxt    = '0;
                tail_nxt    = (VW+1)'(1);
                state_nxt   = ST_Q_POP;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Row of the source is back: set the target bit, fetch the target row.
      // With equal endpoints the second read sees the old row and writes the same bits.
      ST_ADD_S: begin
        adj_we    = 1'b1;
        adj_waddr = src_r;
        adj_wdata = adj_rdata_r | (MAX_VERTICES'(1) << tgt_r);
        adj_re    = 1'b1;
        adj_raddr = tgt_r;
        state_nxt = ST_ADD_T;
      end

      ST_ADD_T: begin
        adj_we    = 1'b1;
        adj_waddr = tgt_r;
        adj_wdata = adj_rdata_r | (MAX_VERTICES'(1) << src_r);
        state_nxt = ST_IDLE;
      end

      // Dequeue the next vertex, or report unreachable once the queue runs dry.
      ST_Q_POP: begin
        if (head_r == tail_r) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.path_exists = 1'b0;
          out_data_nxt.bad_vertex  = 1'b0;
          state_nxt                = ST_IDLE;
        end else begin
          q_re      = 1'b1;
          q_raddr   = head_r[VW-1:0];
          head_nxt  = head_r + (VW+1)'(1);
          state_nxt = ST_Q_ADDR;
        end
      end

      ST_Q_ADDR: begin
        adj_re    = 1'b1;
        adj_raddr = q_rdata_r;
        state_nxt = ST_Q_ROW;
      end

      // Merge the neighbor row; stop early when the target shows up.
      ST_Q_ROW: begin
        if (reach[tgt_r]) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.path_exists = 1'b1;
          out_data_nxt.bad_vertex  = 1'b0;
          state_nxt                = ST_IDLE;
        end else begin
          visited_nxt = visited_r | reach;
          new_nxt     = reach;
          state_nxt   = ST_Q_PUSH;
        end
      end

      // Push the new neighbors lowest first, one a cycle.
      ST_Q_PUSH: begin
        if (new_r == '0) begin
          state_nxt = ST_Q_POP;
        end else begin
          q_we     = 1'b1;
          q_waddr  = tail_r[VW-1:0];
          q_wdata  = ffs_idx;
          tail_nxt = tail_r + (VW+1)'(1);
          new_nxt  = new_r & ~(MAX_VERTICES'(1) << ffs_idx);
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
      vcount_r    <= grq_pkg::COUNT_W'(grq_pkg::COUNT_RESET);
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        vcount_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    src_r      <= src_nxt;
    tgt_r      <= tgt_nxt;
    visited_r  <= visited_nxt;
    new_r      <= new_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    if (adj_re) begin
      adj_rdata_r <= adj_mem[adj_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    if (q_re) begin
      q_rdata_r <= q_mem[q_raddr];
    end
  end

endmodule
